FILE: hdl/hfs_pkg.sv
// Shared types, constants and helpers for the height field sampler.
package hfs_pkg;

  localparam int PatchSide  = 16;
  localparam int MaxPatches = 8;
  localparam int StoreSide  = PatchSide * MaxPatches;
  localparam int CoordW     = $clog2(StoreSide);
  localparam int AddrW      = 2 * CoordW;
  localparam int HeightW    = 16;
  localparam int ZTerm      = 512;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [CoordW:0]    gsize_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_HEIGHT = 2'd1,
    KIND_NORMAL = 2'd2
  } kind_e;

  // Store port request: one write and one read per cycle
  typedef struct packed {
    logic                     we;
    addr_t                    waddr;
    logic [HeightW-1:0]       wdata;
    addr_t                    raddr;
  } store_req_t;

  // Clamp a signed coordinate into [0, size-1]
  function automatic coord_t clamp_coord(input logic signed [CoordW+1:0] c,
                                         input gsize_t size);
    logic signed [CoordW+1:0] lim;
    lim = $signed({1'b0, size}) - (CoordW+2)'(1);
    if (c < 0) begin
      return '0;
    end else if (c > lim) begin
      return lim[CoordW-1:0];
    end
    return c[CoordW-1:0];
  endfunction

  // Map a raw register write onto the supported patch range
  function automatic logic [3:0] clamp_patches(input logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end else if (v > 4'(MaxPatches)) begin
      return 4'(MaxPatches);
    end
    return v;
  endfunction

endpackage

FILE: hdl/heightfield_sampler_top.sv
// Height field sampler: triangle interpolation and normals over a patch grid.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  request  | start / busy        | kind_i, coord_x_i, coord_y_i, height_value_i
//  result   | result_valid_o      | height_out_o, normal_x_o, normal_y_o, normal_z_o
//  config   | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
//  A write request completes in its accept cycle and busy stays low. A height query keeps
//  busy high for three reads from the height memory's single read port, three
//  passes through the shared multiplier, then the result strobe. For a normal query
//  the shared subtractor runs a 31-step divide and a 16-step square root for
//  each of the three components.
//  Reset clears the sequencer and sets both patch counts to 1; the memory holds
//  whatever was last written. The receiver cannot stall: each strobe lasts one cycle.
module heightfield_sampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [14:0] coord_x_i,
  input  logic [14:0] coord_y_i,
  input  logic signed [15:0] height_value_i,
  output logic        result_valid_o,
  output logic signed [15:0] height_out_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [14:0] normal_z_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hfs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CAP  = 4'd2;
  localparam logic [3:0] S_MAC  = 4'd3;
  localparam logic [3:0] S_MACA = 4'd4;
  localparam logic [3:0] S_HOUT = 4'd5;
  localparam logic [3:0] S_SLP  = 4'd6;
  localparam logic [3:0] S_SQX  = 4'd7;
  localparam logic [3:0] S_SQXA = 4'd8;
  localparam logic [3:0] S_SQYA = 4'd9;
  localparam logic [3:0] S_MAG  = 4'd10;
  localparam logic [3:0] S_DIVI = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_SQI  = 4'd13;
  localparam logic [3:0] S_SQ   = 4'd14;
  localparam logic [3:0] S_STO  = 4'd15;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // ---------------- configuration registers ----------------
  logic [3:0] wgrid_q, hgrid_q;
  logic       cfg_we;

  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {28'd0, hgrid_q} : {28'd0, wgrid_q};

  // Update patch counts on a completed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgrid_q <= 4'd1;
      hgrid_q <= 4'd1;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        hgrid_q <= clamp_patches(pwdata[3:0]);
      end else begin
        wgrid_q <= clamp_patches(pwdata[3:0]);
      end
    end
  end

  gsize_t gsx, gsy;
  assign gsx = gsize_t'(wgrid_q * PatchSide);
  assign gsy = gsize_t'(hgrid_q * PatchSide);

  // ---------------- registers ----------------
  logic [3:0]  state_q, state_d;
  logic        norm_q, norm_d;
  coord_t      xi_q, xi_d, yi_q, yi_d;
  logic [7:0]  fx_q, fx_d, fy_q, fy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic signed [15:0] h_q [4];
  logic signed [15:0] h_d [4];
  logic signed [17:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [37:0] acc_q, acc_d, prod_q, prod_d;
  logic [36:0] rem_q, rem_d;
  logic [30:0] quo_q, quo_d, res_q, res_d, bit_q, bit_d;
  logic [1:0]  comp_q, comp_d;
  logic signed [15:0] nx_q, nx_d, ny_q, ny_d;
  logic        valid_q, valid_d;
  logic signed [15:0] hout_q, hout_d, nxo_q, nxo_d, nyo_q, nyo_d;
  logic [14:0] nzo_q, nzo_d;

  logic        accept;
  logic signed [15:0] rdata;
  store_req_t  sreq;

  assign accept = start & ~busy;
  assign busy   = (state_q != S_IDLE);

  // ---------------- read address selection ----------------
  logic signed [CoordW+1:0] xe, ye, x1, y1, rx, ry;
  logic [8:0] fsum;
  logic       upper;

  assign xe    = $signed({2'b00, xi_q});
  assign ye    = $signed({2'b00, yi_q});
  assign x1    = xe + $signed({{(CoordW+1){1'b0}}, (fx_q != 8'd0)});
  assign y1    = ye + $signed({{(CoordW+1){1'b0}}, (fy_q != 8'd0)});
  assign fsum  = {1'b0, fx_q} + {1'b0, fy_q};
  assign upper = fsum[8];

  // Pick the corner or neighbor for the current read
  always_comb begin
    rx = xe;
    ry = ye;
    if (norm_q) begin
      case (cnt_q[1:0])
        2'd0:    rx = xe - (CoordW+2)'(1);
        2'd1:    rx = xe + (CoordW+2)'(1);
        2'd2:    ry = ye - (CoordW+2)'(1);
        default: ry = ye + (CoordW+2)'(1);
      endcase
    end else begin
      case (cnt_q[1:0])
        2'd0:    rx = x1;
        2'd1:    ry = y1;
        default: begin
          if (upper) begin
            rx = x1;
            ry = y1;
          end
        end
      endcase
    end
  end

  // Write on accept when inside the grid; always read the selected point
  always_comb begin
    sreq.we    = accept && (kind_i == KIND_WRITE) &&
                 ({1'b0, coord_x_i[14:8]} < gsx) && ({1'b0, coord_y_i[14:8]} < gsy);
    sreq.waddr = {coord_y_i[14:8], coord_x_i[14:8]};
    sreq.wdata = height_value_i;
    sreq.raddr = {clamp_coord(ry, gsy), clamp_coord(rx, gsx)};
  end

  hfs_store u_store (
    .clk_i  (clk_i),
    .req_i  (sreq),
    .rdata_o(rdata)
  );

  // ---------------- shared multiplier ----------------
  logic [8:0]  wgt;
  logic signed [17:0] cval;
  logic        cneg;
  logic [17:0] mag;
  logic signed [18:0] mul_a, mul_b;

  // Barycentric weight for the current corner
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    wgt = upper ? (9'd256 - {1'b0, fy_q}) : {1'b0, fx_q};
      2'd1:    wgt = upper ? (9'd256 - {1'b0, fx_q}) : {1'b0, fy_q};
      default: wgt = upper ? {1'b0, fsum[7:0]} : (9'd256 - fsum);
    endcase
  end

  // Component under normalization and its magnitude
  always_comb begin
    case (comp_q)
      COMP_X:  cval = sx_q;
      COMP_Y:  cval = sy_q;
      default: cval = 18'sd512;
    endcase
    cneg = cval[17];
    mag  = cneg ? 18'(-cval) : 18'(cval);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MAC: begin
        mul_a = {{3{h_q[cnt_q[1:0]][15]}}, h_q[cnt_q[1:0]]};
        mul_b = {10'd0, wgt};
      end
      S_SQX: begin
        mul_a = {sx_q[17], sx_q};
        mul_b = {sx_q[17], sx_q};
      end
      S_SQXA: begin
        mul_a = {sy_q[17], sy_q};
        mul_b = {sy_q[17], sy_q};
      end
      S_MAG: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, mag};
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ---------------- shared subtractor ----------------
  logic [36:0] sub_a, sub_b;
  logic [37:0] sub_diff;
  logic        sub_ge;
  logic [30:0] res_bit;

  assign res_bit = res_q + bit_q;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    if (state_q == S_DIV) begin
      sub_a = (cnt_q == 5'd30) ? rem_q : {rem_q[35:0], 1'b0};
      sub_b = acc_q[36:0];
    end else if (state_q == S_SQ) begin
      sub_a = rem_q;
      sub_b = {6'd0, res_bit};
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[37];

  // ---------------- sequencer ----------------
  logic signed [16:0] dx, dy;
  logic signed [29:0] hr;
  logic [15:0] nfull;
  logic [14:0] nmag;
  logic signed [15:0] nsgn;

  assign dx    = 17'(h_q[0]) - 17'(h_q[1]);
  assign dy    = 17'(h_q[2]) - 17'(h_q[3]);
  assign hr    = 30'((acc_q + 38'sd128) >>> 8);
  assign nfull = res_q[15:0] + 16'd1;
  assign nmag  = nfull[15:1];
  assign nsgn  = cneg ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});

  always_comb begin
    state_d = state_q;
    norm_d  = norm_q;
    xi_d    = xi_q;
    yi_d    = yi_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    cnt_d   = cnt_q;
    h_d     = h_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    res_d   = res_q;
    bit_d   = bit_q;
    comp_d  = comp_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    valid_d = 1'b0;
    hout_d  = hout_q;
    nxo_d   = nxo_q;
    nyo_d   = nyo_q;
    nzo_d   = nzo_q;
    unique case (state_q)
      S_IDLE: begin
        // Take a query; writes finish in the accept cycle
        if (accept && (kind_i == KIND_HEIGHT || kind_i == KIND_NORMAL)) begin
          norm_d  = (kind_i == KIND_NORMAL);
          xi_d    = coord_x_i[14:8];
          yi_d    = coord_y_i[14:8];
          fx_d    = coord_x_i[7:0];
          fy_d    = coord_y_i[7:0];
          cnt_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        h_d[cnt_q[1:0]] = rdata;
        if ((norm_q && cnt_q == 5'd3) || (!norm_q && cnt_q == 5'd2)) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = norm_q ? S_SLP : S_MAC;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_RD;
        end
      end
      S_MAC: state_d = S_MACA;
      S_MACA: begin
        acc_d = acc_q + prod_q;
        if (cnt_q == 5'd2) begin
          state_d = S_HOUT;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_MAC;
        end
      end
      S_HOUT: begin
        // Round half up and saturate
        if (hr > 30'sd32767) begin
          hout_d = 16'sh7fff;
        end else if (hr < -30'sd32768) begin
          hout_d = 16'sh8000;
        end else begin
          hout_d = hr[15:0];
        end
        nxo_d   = '0;
        nyo_d   = '0;
        nzo_d   = '0;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SLP: begin
        // Double slopes at the low edge or beyond the grid
        sx_d = ((xi_q == '0) || ({1'b0, xi_q} >= gsx)) ? {dx, 1'b0} : 18'(dx);
        sy_d = ((yi_q == '0) || ({1'b0, yi_q} >= gsy)) ? {dy, 1'b0} : 18'(dy);
        state_d = S_SQX;
      end
      S_SQX:  state_d = S_SQXA;
      S_SQXA: begin
        acc_d   = prod_q;
        state_d = S_SQYA;
      end
      S_SQYA: begin
        acc_d   = acc_q + prod_q + 38'(ZTerm * ZTerm);
        comp_d  = COMP_X;
        state_d = S_MAG;
      end
      S_MAG: state_d = S_DIVI;
      S_DIVI: begin
        rem_d   = prod_q[36:0];
        quo_d   = '0;
        cnt_d   = 5'd30;
        state_d = S_DIV;
      end
      S_DIV: begin
        // One quotient bit per cycle
        rem_d = sub_ge ? sub_diff[36:0] : sub_a;
        quo_d = {quo_q[29:0], sub_ge};
        if (cnt_q == 5'd0) begin
          state_d = S_SQI;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_SQI: begin
        rem_d   = {6'd0, quo_q};
        res_d   = '0;
        bit_d   = 31'd1 << 30;
        cnt_d   = 5'd15;
        state_d = S_SQ;
      end
      S_SQ: begin
        // One result bit per cycle
        if (sub_ge) begin
          rem_d = sub_diff[36:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == 5'd0) begin
          state_d = S_STO;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_STO: begin
        case (comp_q)
          COMP_X: begin
            nx_d    = nsgn;
            comp_d  = COMP_Y;
            state_d = S_MAG;
          end
          COMP_Y: begin
            ny_d    = nsgn;
            comp_d  = COMP_Z;
            state_d = S_MAG;
          end
          default: begin
            hout_d  = '0;
            nxo_d   = nx_q;
            nyo_d   = ny_q;
            nzo_d   = nmag;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    xi_q   <= xi_d;
    yi_q   <= yi_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    cnt_q  <= cnt_d;
    h_q    <= h_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    comp_q <= comp_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    hout_q <= hout_d;
    nxo_q  <= nxo_d;
    nyo_q  <= nyo_d;
    nzo_q  <= nzo_d;
  end

  assign result_valid_o = valid_q;
  assign height_out_o   = hout_q;
  assign normal_x_o     = nxo_q;
  assign normal_y_o     = nyo_q;
  assign normal_z_o     = nzo_q;

endmodule

FILE: hdl/hfs_store.sv
// Height memory with one write port, one read port and registered read data.
module hfs_store (
  input  logic                               clk_i,
  input  hfs_pkg::store_req_t                req_i,
  output logic signed [hfs_pkg::HeightW-1:0] rdata_o
);
  import hfs_pkg::*;

  logic [HeightW-1:0] mem [StoreSide*StoreSide];
  logic [HeightW-1:0] rdata_q;

  // Write a point, read one point a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = $signed(rdata_q);

endmodule

FILE: hdl/heightfield_sampler_checker.sv
// Port-level checks for the height field sampler, bound to the top level.
module heightfield_sampler_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  kind_i,
  input logic        result_valid_o,
  input logic signed [15:0] height_out_o,
  input logic signed [15:0] normal_x_o,
  input logic signed [15:0] normal_y_o,
  input logic [14:0] normal_z_o
);
  import hfs_pkg::*;

  // A write request never occupies the block
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_WRITE) |=> !busy)
    else $error("write request left the block busy");

  // A query request occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_HEIGHT || kind_i == KIND_NORMAL)) |=> busy)
    else $error("query request not taken");

  // Results are single-cycle pulses
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held");

  // A result finishes the query
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  // A result carries either a height or a normal
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (height_out_o == 16'sd0 ||
                        (normal_x_o == 16'sd0 && normal_y_o == 16'sd0 &&
                         normal_z_o == 15'd0)))
    else $error("mixed result");

endmodule

bind heightfield_sampler_top heightfield_sampler_checker u_checker (.*);
